// ===== src/pdst_pkg.sv =====
// Shared types and constants for the per-destination sequence table.
// Used by the channel interfaces, the compare unit and the top level.
package pdst_pkg;

  // Fixed field widths of the request and response beats.
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned TIME_W   = 63;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned TMO_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned EVCNT_W  = 5;

  // Reset value of the aging timeout in microseconds.
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd1000000;

  // Saturation limit of the eviction count.
  localparam logic [EVCNT_W-1:0] EVICT_MAX = '1;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED = 2'd0,
    ST_CREATED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // Result of the shared compare unit for one entry.
  typedef struct packed {
    logic aged;
    logic match;
  } cmp_res_t;

endpackage

// ===== src/pdst_req_if.sv =====
// Request channel: valid/ready handshake carrying a key and a time stamp.
// Depends on pdst_pkg for field widths.
interface pdst_req_if;
  logic                          valid;
  logic                          ready;
  logic [pdst_pkg::KEY_W-1:0]    dest_key;
  logic [pdst_pkg::TIME_W-1:0]   now_us;

  modport source (output valid, output dest_key, output now_us, input ready);
  modport sink   (input valid, input dest_key, input now_us, output ready);
endinterface

// ===== src/pdst_rsp_if.sv =====
// Response channel: valid/ready handshake carrying sequence, status and count.
// Depends on pdst_pkg for field widths.
interface pdst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pdst_pkg::SEQ_W-1:0]    seq_number;
  logic [pdst_pkg::STATUS_W-1:0] status;
  logic [pdst_pkg::EVCNT_W-1:0]  evicted_count;

  modport source (output valid, output seq_number, output status, output evicted_count,
                  input ready);
  modport sink   (input valid, input seq_number, input status, input evicted_count,
                  output ready);
endinterface

// ===== src/pdst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pdst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pdst_cmp_unit.sv =====
// Shared compare unit: age test against the timeout and key match of one entry.
// Depends on pdst_pkg for widths and the result struct.
module pdst_cmp_unit #(
  parameter int unsigned KW = 32
) (
  input  logic [pdst_pkg::TIME_W-1:0] now_i,
  input  logic [pdst_pkg::TIME_W-1:0] last_i,
  input  logic [pdst_pkg::TMO_W-1:0]  timeout_i,
  input  logic [KW-1:0]               req_key_i,
  input  logic [KW-1:0]               ent_key_i,
  output pdst_pkg::cmp_res_t          res_o
);
  import pdst_pkg::*;

  logic [TIME_W:0] diff;

  // One subtract gives both the age and whether time went backwards.
  assign diff = {1'b0, now_i} - {1'b0, last_i};

  always_comb begin
    res_o.aged  = !diff[TIME_W] && (diff[TIME_W-1:0] >= {{(TIME_W-TMO_W){1'b0}}, timeout_i});
    res_o.match = (req_key_i == ent_key_i);
  end

endmodule

// ===== src/per_destination_sequence_table.sv =====
// Per-destination sequence table. Each accepted request makes one pass over the
// entries at one RAM read a cycle, through one shared age/key compare unit, then
// goes through a write state and loads its response into the output register.
// A new request is taken once the response sits in the output register,
// even while that response still waits.
// Reset (rst_ni low, asynchronous) clears all valid bits and sets the timeout to 1000000.
module per_destination_sequence_table #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       timeout_we_i,
  input  logic [pdst_pkg::TMO_W-1:0] timeout_wdata_i,
  pdst_req_if.sink                   req_i,
  pdst_rsp_if.source                 rsp_o
);
  import pdst_pkg::*;

  localparam int unsigned KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned EW = KW + SEQ_W + TIME_W;
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [TMO_W-1:0]    timeout_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [KW-1:0]       key_q;
  logic [TIME_W-1:0]   now_q;
  logic [CW-1:0]       cnt_q;
  logic                chk_vld_q;
  logic [IW-1:0]       chk_idx_q;
  logic                hit_found_q, free_found_q;
  logic [IW-1:0]       hit_idx_q, free_idx_q;
  logic [SEQ_W-1:0]    hit_seq_q;
  logic [EVCNT_W-1:0]  evict_cnt_q;
  logic [SEQ_W-1:0]    res_seq_q;
  status_e             res_status_q;
  logic                out_vld_q;
  logic [SEQ_W-1:0]    out_seq_q;
  status_e             out_status_q;
  logic [EVCNT_W-1:0]  out_evict_q;

  logic                in_fire, issue, load_out, ram_we, ent_live;
  logic [IW-1:0]       waddr;
  logic [EW-1:0]       wdata, rdata;
  logic [KW-1:0]       ent_key;
  logic [SEQ_W-1:0]    ent_seq;
  logic [TIME_W-1:0]   ent_time;
  cmp_res_t            cmp;

  // Entry storage: key, sequence number and last time in one word.
  pdst_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (cnt_q[IW-1:0]),
    .rdata_o (rdata)
  );

  assign ent_key  = rdata[EW-1 -: KW];
  assign ent_seq  = rdata[TIME_W +: SEQ_W];
  assign ent_time = rdata[TIME_W-1:0];

  // Age and key compare, reused for every entry of the pass.
  pdst_cmp_unit #(.KW(KW)) u_cmp (
    .now_i     (now_q),
    .last_i    (ent_time),
    .timeout_i (timeout_q),
    .req_key_i (key_q),
    .ent_key_i (ent_key),
    .res_o     (cmp)
  );

  // Handshake and sequencing controls.
  assign req_i.ready = (state_q == S_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign issue       = (state_q == S_SCAN) && (cnt_q != LAST_CNT);
  assign load_out    = (state_q == S_DONE) && (!out_vld_q || rsp_o.ready);
  assign ent_live    = valid_q[chk_idx_q] && !cmp.aged;

  // Write on a hit, or on a miss with a free entry.
  assign ram_we = (state_q == S_WRITE) && (hit_found_q || free_found_q);
  assign waddr  = hit_found_q ? hit_idx_q : free_idx_q;
  assign wdata  = {key_q, (hit_found_q ? SEQ_W'(hit_seq_q + 1'b1) : SEQ_W'(1)), now_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_SCAN;
      S_SCAN:  if (cnt_q == LAST_CNT && chk_vld_q) state_d = S_WRITE;
      S_WRITE: state_d = S_DONE;
      S_DONE:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state: sequencer, timeout register, valid bits and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      timeout_q <= TIMEOUT_RESET;
      valid_q   <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (timeout_we_i) timeout_q <= timeout_wdata_i;
      chk_vld_q <= issue;
      if (chk_vld_q && cmp.aged) valid_q[chk_idx_q] <= 1'b0;
      if (state_q == S_WRITE && !hit_found_q && free_found_q) valid_q[free_idx_q] <= 1'b1;
      if (load_out) out_vld_q <= 1'b1;
      else if (rsp_o.ready) out_vld_q <= 1'b0;
    end
  end

  // Datapath: request capture, scan bookkeeping and result registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q        <= req_i.dest_key[KW-1:0];
      now_q        <= req_i.now_us;
      cnt_q        <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      evict_cnt_q  <= '0;
    end
    if (issue) begin
      cnt_q     <= cnt_q + 1'b1;
      chk_idx_q <= cnt_q[IW-1:0];
    end
    if (chk_vld_q) begin
      if (valid_q[chk_idx_q] && cmp.aged && evict_cnt_q != EVICT_MAX) begin
        evict_cnt_q <= evict_cnt_q + 1'b1;
      end
      if (ent_live && cmp.match && !hit_found_q) begin
        hit_found_q <= 1'b1;
        hit_idx_q   <= chk_idx_q;
        hit_seq_q   <= ent_seq;
      end
      if (!ent_live && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= chk_idx_q;
      end
    end
    if (state_q == S_WRITE) begin
      if (hit_found_q) begin
        res_seq_q    <= SEQ_W'(hit_seq_q + 1'b1);
        res_status_q <= ST_UPDATED;
      end else if (free_found_q) begin
        res_seq_q    <= SEQ_W'(1);
        res_status_q <= ST_CREATED;
      end else begin
        res_seq_q    <= '0;
        res_status_q <= ST_FULL;
      end
    end
    if (load_out) begin
      out_seq_q    <= res_seq_q;
      out_status_q <= res_status_q;
      out_evict_q  <= evict_cnt_q;
    end
  end

  // Response beat.
  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.seq_number    = out_seq_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.evicted_count = out_evict_q;

  // A dropped send always reports sequence zero.
  a_full_zero_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q == ST_FULL) |-> (out_seq_q == '0))
    else $error("dropped send reports a nonzero sequence number");

  // A hit found in the pass still points at a live entry when written.
  a_hit_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && hit_found_q) |-> valid_q[hit_idx_q])
    else $error("hit entry is not valid at write time");

  // A newly created entry becomes valid.
  a_new_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && !hit_found_q && free_found_q) |=> valid_q[$past(free_idx_q)])
    else $error("created entry not marked valid");

  // RAM reads happen only during the pass.
  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> (state_q == S_SCAN))
    else $error("entry check outside the scan pass");

endmodule
